### rtl/core/reference_count_aging_table_macros.svh
// Assertion macros for the reference count aging table.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef REFERENCE_COUNT_AGING_TABLE_MACROS_SVH
`define REFERENCE_COUNT_AGING_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define RCAT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rcat check failed");
`define RCAT_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rcat forbidden condition seen");
`else
`define RCAT_ASSERT(label, clk, rst, prop)
`define RCAT_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### rtl/core/rcat_pkg.sv
// Shared constants and types of the reference count aging table.
// No dependencies.
`default_nettype none

package rcat_pkg;

   localparam int CAPACITY   = 64;
   localparam int COUNT_BITS = 16;
   localparam int KEY_W      = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int OUT_W      = 7;
   localparam int STATUS_W   = 3;

   typedef enum logic [1:0] {
      OP_REFERENCE = 2'd0,
      OP_CLEAN     = 2'd1,
      OP_SHUTDOWN  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT      = 3'd0,
      STATUS_INSERTED = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_REJECTED = 3'd3,
      STATUS_DONE     = 3'd4
   } status_type;

   // token walking the cell row, one cell per clock
   typedef struct packed {
      logic             active;
      logic             sweep;
      logic             hit;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic [CNT_W-1:0] dropped;
   } token_type;

   // insert broadcast to the row
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
   } write_type;

endpackage

`default_nettype wire

### rtl/core/rcat_cell.sv
// One table entry: valid bit, key and reference count, plus a token stage.
// Depends on rcat_pkg.
`default_nettype none

module rcat_cell
   import rcat_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire logic [KEY_W-1:0] lookup_key,
   input  wire token_type        up_tok,
   input  wire write_type        wr,
   output token_type             dn_tok
);

   logic                  valid_ff, valid_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   token_type             dn_tok_ff, dn_tok_in;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      dn_tok_in = up_tok;
      if (up_tok.active) begin
         if (up_tok.sweep) begin
            if (valid_ff) begin
               if (count_ff <= COUNT_BITS'(1)) begin
                  valid_in          = 1'b0;
                  dn_tok_in.dropped = up_tok.dropped + CNT_W'(1);
               end else begin
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
         end else begin
            if (valid_ff && key_ff == lookup_key) begin
               dn_tok_in.hit = 1'b1;
               if (count_ff != {COUNT_BITS{1'b1}}) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end else if (!valid_ff && !up_tok.free_found) begin
               dn_tok_in.free_found = 1'b1;
               dn_tok_in.free_idx   = cell_idx;
            end
         end
      end
      if (wr.en && wr.idx == cell_idx) begin
         valid_in = 1'b1;
         key_in   = wr.key;
         count_in = COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dn_tok_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         dn_tok_ff <= dn_tok_in;
      end
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign dn_tok = dn_tok_ff;

endmodule

`default_nettype wire

### rtl/core/reference_count_aging_table.sv
// Top level of the reference count aging table: control and the cell row.
// Depends on rcat_pkg, rcat_cell and reference_count_aging_table_macros.svh.
//
//   channel   ports                             handshake
//   request   req_opcode, req_key               start && !busy
//   response  rsp_status, rsp_occupancy,        rsp_valid, one cycle
//             rsp_removed
//
// Reference and clean: a token walks the row one cell per clock, from the
// launch register through every cell to the response register; busy is high meanwhile.
// Shutdown and rejected transactions respond in the next cycle, busy stays low.
// Reset clears every valid bit at once; no clearing pass.
// The receiver cannot stall; each response is shown for one cycle only.
`default_nettype none
`include "reference_count_aging_table_macros.svh"

module reference_count_aging_table
   import rcat_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_opcode,
   input  wire logic signed [31:0]  req_key,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [OUT_W-1:0]         rsp_occupancy,
   output logic [OUT_W-1:0]         rsp_removed
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic             halted_ff, halted_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [KEY_W-1:0] key_ff, key_in;
   token_type        launch_ff, launch_in;
   write_type        wr_ff, wr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0] rsp_occupancy_ff, rsp_occupancy_in;
   logic [OUT_W-1:0] rsp_removed_ff, rsp_removed_in;

   token_type cell_up  [CAPACITY];
   token_type cell_dn  [CAPACITY];
   token_type tail_tok;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_row
      if (i == 0) begin : g_head
         assign cell_up[i] = launch_ff;
      end else begin : g_link
         assign cell_up[i] = cell_dn[i-1];
      end
      rcat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .lookup_key (key_ff),
         .up_tok     (cell_up[i]),
         .wr         (wr_ff),
         .dn_tok     (cell_dn[i])
      );
   end

   assign tail_tok = cell_dn[CAPACITY-1];

   always_comb begin
      state_in         = state_ff;
      halted_in        = halted_ff;
      live_in          = live_ff;
      key_in           = key_ff;
      launch_in        = '0;
      wr_in            = '0;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rsp_removed_in   = rsp_removed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_occupancy_in = OUT_W'(live_ff);
               rsp_removed_in   = '0;
               if (req_opcode == OP_SHUTDOWN) begin
                  halted_in     = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_DONE;
               end else if (halted_ff || (req_opcode != OP_REFERENCE &&
                                          req_opcode != OP_CLEAN)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_REJECTED;
               end else begin
                  launch_in.active = 1'b1;
                  launch_in.sweep  = (req_opcode == OP_CLEAN);
                  key_in           = req_key;
                  state_in         = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (tail_tok.active) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_removed_in = '0;
               if (tail_tok.sweep) begin
                  live_in        = live_ff - tail_tok.dropped;
                  rsp_status_in  = STATUS_DONE;
                  rsp_removed_in = OUT_W'(tail_tok.dropped);
               end else if (tail_tok.hit) begin
                  rsp_status_in = STATUS_HIT;
               end else if (tail_tok.free_found) begin
                  wr_in.en      = 1'b1;
                  wr_in.idx     = tail_tok.free_idx;
                  wr_in.key     = key_ff;
                  live_in       = live_ff + CNT_W'(1);
                  rsp_status_in = STATUS_INSERTED;
               end else begin
                  rsp_status_in = STATUS_FULL;
               end
               rsp_occupancy_in = OUT_W'(live_in);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halted_ff    <= 1'b0;
         live_ff      <= '0;
         launch_ff    <= '0;
         wr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         live_ff      <= live_in;
         launch_ff    <= launch_in;
         wr_ff        <= wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
      rsp_removed_ff   <= rsp_removed_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_removed   = rsp_removed_ff;

   `RCAT_ASSERT_NEVER(a_tail_outside_run, clock, reset, tail_tok.active && state_ff != ST_RUN)
   `RCAT_ASSERT_NEVER(a_write_with_launch, clock, reset, wr_ff.en && launch_ff.active)
   `RCAT_ASSERT(a_live_bound, clock, reset, live_ff <= CNT_W'(CAPACITY))
   `RCAT_ASSERT(a_tail_responds, clock, reset, tail_tok.active |=> rsp_valid_ff && !busy)

endmodule

`default_nettype wire

### tb/reference_count_aging_table_tb.sv
// Self-checking testbench for reference_count_aging_table.
// Uses rcat_pkg for widths, opcodes and status codes; predicts every response
// with its own copy of the key table and checks responses in order.
module reference_count_aging_table_tb;
   import rcat_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
   localparam int POOL_SIZE = 96;
   localparam int RANDOM_ITEMS = 1040;

   typedef struct packed {
      status_type       status;
      logic [OUT_W-1:0] occupancy;
      logic [OUT_W-1:0] removed;
   } rcat_response_type;

   class aging_table_scoreboard;
      bit                    slot_valid[CAPACITY];
      logic [KEY_W-1:0]      slot_key[CAPACITY];
      logic [COUNT_BITS-1:0] slot_count[CAPACITY];
      int                    live;
      bit                    halted;
      rcat_response_type     expected_responses[$];
      int                    mismatches;

      function void note_request(logic [1:0] op, logic [KEY_W-1:0] key);
         rcat_response_type r;
         int                free_slot;
         bit                found;
         int                dropped;
         dropped = 0;
         if (op == OP_SHUTDOWN) begin
            halted   = 1'b1;
            r.status = STATUS_DONE;
         end else if (halted || op == OP_UNUSED) begin
            r.status = STATUS_REJECTED;
         end else if (op == OP_REFERENCE) begin
            found     = 1'b0;
            free_slot = -1;
            for (int i = 0; i < CAPACITY; i++) begin
               if (slot_valid[i]) begin
                  if (!found && slot_key[i] == key) begin
                     found = 1'b1;
                     if (slot_count[i] != COUNT_TOP)
                        slot_count[i] = slot_count[i] + 1'b1;
                  end
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (found) begin
               r.status = STATUS_HIT;
            end else if (free_slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot]   = key;
               slot_count[free_slot] = COUNT_BITS'(1);
               live++;
               r.status = STATUS_INSERTED;
            end
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (slot_valid[i]) begin
                  if (slot_count[i] <= COUNT_BITS'(1)) begin
                     slot_valid[i] = 1'b0;
                     slot_count[i] = '0;
                     dropped++;
                  end else begin
                     slot_count[i] = slot_count[i] - 1'b1;
                  end
               end
            end
            live -= dropped;
            r.status = STATUS_DONE;
         end
         r.occupancy = live[OUT_W-1:0];
         r.removed   = dropped[OUT_W-1:0];
         expected_responses.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [OUT_W-1:0] occupancy,
                                   logic [OUT_W-1:0] removed);
         rcat_response_type exp_r;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d occupancy %0d removed %0d",
                        status, occupancy, removed);
            return;
         end
         exp_r = expected_responses.pop_front();
         if (status !== exp_r.status || occupancy !== exp_r.occupancy ||
             removed !== exp_r.removed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: status %0d/%0d occupancy %0d/%0d removed %0d/%0d (exp/act)",
                        exp_r.status, status, exp_r.occupancy, occupancy,
                        exp_r.removed, removed);
         end
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic [1:0]              req_opcode = 2'd0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [OUT_W-1:0]        rsp_occupancy;
   logic [OUT_W-1:0]        rsp_removed;

   aging_table_scoreboard aging_sb = new();

   always #5 clock = ~clock;

   reference_count_aging_table dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_occupancy(rsp_occupancy),
      .rsp_removed  (rsp_removed)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         aging_sb.check_response(rsp_status, rsp_occupancy, rsp_removed);
   end

   task automatic issue(input logic [1:0] op, input logic [KEY_W-1:0] key,
                        input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(99) < 37) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_key    <= key;
      do @(posedge clock); while (busy);
      aging_sb.note_request(op, key);
   endtask

   initial begin
      logic [KEY_W-1:0] key_pool[POOL_SIZE];
      logic [KEY_W-1:0] key;
      logic [1:0]       op;
      bit               filling;
      int               segment_left;
      int               pool_span;
      int               pick;
      bit               may_idle;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty sweep, key extremes, hits, unused opcode, aging to zero
      issue(OP_CLEAN, '0, 1'b1);
      issue(OP_REFERENCE, 32'h8000_0000, 1'b1);
      issue(OP_REFERENCE, 32'h7FFF_FFFF, 1'b1);
      issue(OP_REFERENCE, 32'h0000_0000, 1'b0);
      issue(OP_REFERENCE, 32'hFFFF_FFFF, 1'b0);
      issue(OP_REFERENCE, 32'h8000_0000, 1'b1);
      issue(OP_REFERENCE, 32'h7FFF_FFFF, 1'b1);
      issue(OP_REFERENCE, 32'h7FFF_FFFF, 1'b0);
      issue(OP_UNUSED, $urandom, 1'b1);
      issue(OP_REFERENCE, 32'h0000_0001, 1'b1);
      issue(OP_CLEAN, $urandom, 1'b1);
      issue(OP_REFERENCE, 32'h7FFF_FFFF, 1'b0);
      issue(OP_CLEAN, '0, 1'b1);
      issue(OP_CLEAN, 32'hFFFF_FFFF, 1'b0);
      issue(OP_REFERENCE, 32'hFFFF_FFFE, 1'b1);
      issue(OP_UNUSED, 32'h8000_0000, 1'b0);

      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      // alternate fill stretches (table runs full) with aging stretches
      filling      = 1'b1;
      segment_left = $urandom_range(100, 160);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (segment_left == 0) begin
            filling      = !filling;
            segment_left = filling ? $urandom_range(100, 160) : $urandom_range(40, 100);
         end
         segment_left--;
         pool_span = filling ? POOL_SIZE : 32;
         pick      = $urandom_range(99);
         if (pick < (filling ? 2 : 25))
            op = OP_CLEAN;
         else if (pick < (filling ? 4 : 28))
            op = OP_UNUSED;
         else
            op = OP_REFERENCE;
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(pool_span - 1)];
         else
            key = $urandom;
         may_idle = !(n >= 400 && n < 600);
         issue(op, key, may_idle);
      end

      // shutdown, then every other opcode is rejected; repeated shutdown still done
      issue(OP_SHUTDOWN, $urandom, 1'b1);
      for (int n = 0; n < 20; n++)
         issue(2'($urandom_range(3)), key_pool[$urandom_range(POOL_SIZE - 1)], 1'b1);
      issue(OP_SHUTDOWN, '0, 1'b0);
      issue(OP_CLEAN, '0, 1'b0);
      start <= 1'b0;

      while (aging_sb.pending() != 0)
         @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      if (aging_sb.mismatches == 0 && aging_sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
